@@ rtl/iqddc_pkg.sv @@
`timescale 1ns / 1ps
package iqddc_pkg;

   localparam int MAX_DECIM_DEF  = 4096;
   localparam int TABLE_BITS_DEF = 10;

   localparam logic [31:0] NCO_STEP_RST = 32'd0;
   localparam logic [31:0] IN_RATE_RST  = 32'd8000000;
   localparam logic [31:0] OUT_RATE_RST = 32'd48000;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NCO_STEP = 2'd0,
      CSR_IN_RATE  = 2'd1,
      CSR_OUT_RATE = 2'd2
   } csr_idx_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic look;
      logic mul;
      logic acc;
      logic num;
      logic div_start;
      logic div_q;
      logic load_out;
   } iqddc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
      logic div_done;
   } iqddc_stat_type;

endpackage

@@ rtl/iqddc_in_if.sv @@
`timescale 1ns / 1ps
interface iqddc_in_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] in_i;
   logic signed [15:0] in_q;

   modport source (output valid, output in_i, output in_q, input ready);
   modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

@@ rtl/iqddc_out_if.sv @@
`timescale 1ns / 1ps
interface iqddc_out_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_i;
   logic signed [15:0] out_q;

   modport source (output valid, output out_i, output out_q, input ready);
   modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

@@ rtl/iqddc_csr_if.sv @@
`timescale 1ns / 1ps
interface iqddc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [iqddc_pkg::CSR_IDX_W-1:0]  index;
   logic [31:0]                      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/iqddc_div.sv @@
`timescale 1ns / 1ps
module iqddc_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/iqddc_dp.sv @@
`timescale 1ns / 1ps
module iqddc_dp #(
   parameter int MAX_DECIM  = iqddc_pkg::MAX_DECIM_DEF,
   parameter int TABLE_BITS = iqddc_pkg::TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  iqddc_pkg::iqddc_cmd_type        cmd,
   output iqddc_pkg::iqddc_stat_type       stat,
   input  logic                            csr_we,
   input  logic [iqddc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data,
   input  logic signed [15:0]              in_i,
   input  logic signed [15:0]              in_q,
   output logic signed [15:0]              out_i,
   output logic signed [15:0]              out_q
);

   localparam int QTR_N = (1 << TABLE_BITS) / 4;
   localparam int QA_W  = TABLE_BITS - 1;
   localparam int CNT_W = $clog2(MAX_DECIM + 1);
   localparam int SUM_W = 17 + CNT_W;

   typedef logic [14:0] qtab_type [QTR_N+1];

   function automatic logic [63:0] next_term(input logic [63:0] t, input logic [63:0] x);
      logic [63:0] a;
      a = (t * x) >> 30;
      return (a * x) >> 30;
   endfunction

   // Q30 odd power series of sin, rounded to Q15
   function automatic logic [14:0] sin_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        t;
      logic signed [63:0] acc;
      logic [63:0]        v;
      x   = (64'd6746518852 * 64'(k)) >> TABLE_BITS;
      t   = x;
      acc = 0;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd6;
      acc = acc - $signed(t); t = next_term(t, x) / 64'd20;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd42;
      acc = acc - $signed(t); t = next_term(t, x) / 64'd72;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd110;
      acc = acc - $signed(t); t = next_term(t, x) / 64'd156;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd210;
      acc = acc - $signed(t); t = next_term(t, x) / 64'd272;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd342;
      acc = acc - $signed(t); t = next_term(t, x) / 64'd420;
      acc = acc + $signed(t); t = next_term(t, x) / 64'd506;
      acc = acc - $signed(t);
      if (acc < 0) acc = 0;
      v = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[14:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int k = 0; k <= QTR_N; k++) tab[k] = sin_entry(k);
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   function automatic logic signed [15:0] tab_sin(input logic [TABLE_BITS-1:0] k);
      logic [QA_W-1:0] r;
      logic [14:0]     m;
      r = QA_W'(k[TABLE_BITS-3:0]);
      if (k[TABLE_BITS-2]) m = QTAB[QA_W'(QTR_N) - r];
      else                 m = QTAB[r];
      return k[TABLE_BITS-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   // configuration
   logic [31:0] step_ff, in_rate_ff, out_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= iqddc_pkg::NCO_STEP_RST;
         in_rate_ff  <= iqddc_pkg::IN_RATE_RST;
         out_rate_ff <= iqddc_pkg::OUT_RATE_RST;
      end else if (csr_we) begin
         case (iqddc_pkg::csr_idx_type'(csr_index))
            iqddc_pkg::CSR_NCO_STEP: step_ff     <= csr_data;
            iqddc_pkg::CSR_IN_RATE:  in_rate_ff  <= csr_data;
            iqddc_pkg::CSR_OUT_RATE: out_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [31:0]              phase_ff;
   logic [32:0]              rp_ff, rpsum_ff;
   logic                     emit_ff;
   logic signed [15:0]       si_ff, sq_ff, sin_ff, cos_ff;
   logic signed [31:0]       p_ic_ff, p_qs_ff, p_is_ff, p_qc_ff;
   logic signed [SUM_W-1:0]  sum_i_ff, sum_q_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [SUM_W-1:0]         num_i_ff, num_q_ff;
   logic                     neg_i_ff, neg_q_ff, zero_ff;
   logic [CNT_W-1:0]         den_ff;
   logic signed [15:0]       res_i_ff, res_q_ff, out_i_ff, out_q_ff;

   logic [TABLE_BITS-1:0]    idx, cidx;
   logic [32:0]              modulus, diff;
   logic signed [32:0]       mix_i, mix_q;
   logic signed [17:0]       rnd_i, rnd_q;
   logic [SUM_W-1:0]         mag_i, mag_q;
   logic                     div_done;
   logic [SUM_W-1:0]         quo;
   logic signed [15:0]       res;

   assign idx     = phase_ff[31 -: TABLE_BITS];
   assign cidx    = idx + TABLE_BITS'(QTR_N);
   assign modulus = (in_rate_ff == 32'd0) ? 33'd1 : {1'b0, in_rate_ff};
   assign diff    = rpsum_ff - modulus;
   assign mix_i   = 33'(p_ic_ff) - 33'(p_qs_ff) + 33'sd16384;
   assign mix_q   = 33'(p_is_ff) + 33'(p_qc_ff) + 33'sd16384;
   assign rnd_i   = 18'(mix_i >>> 15);
   assign rnd_q   = 18'(mix_q >>> 15);
   assign mag_i   = sum_i_ff[SUM_W-1] ? SUM_W'(-sum_i_ff) : SUM_W'(sum_i_ff);
   assign mag_q   = sum_q_ff[SUM_W-1] ? SUM_W'(-sum_q_ff) : SUM_W'(sum_q_ff);

   iqddc_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_q ? num_q_ff : num_i_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // rounded average magnitude, signed and saturated
   always_comb begin
      logic neg;
      neg = cmd.div_q ? neg_q_ff : neg_i_ff;
      if (zero_ff) begin
         res = '0;
      end else if (neg) begin
         res = (quo > SUM_W'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, quo}));
      end else begin
         res = (quo > SUM_W'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         rp_ff    <= '0;
         sum_i_ff <= '0;
         sum_q_ff <= '0;
         cnt_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         if (cmd.accept) phase_ff <= phase_ff + step_ff;
         if (cmd.look) begin
            if (rpsum_ff >= modulus) begin
               rp_ff   <= (diff >= modulus) ? modulus - 33'd1 : diff;
               emit_ff <= 1'b1;
            end else begin
               rp_ff   <= rpsum_ff;
               emit_ff <= 1'b0;
            end
         end
         if (cmd.acc && cnt_ff < CNT_W'(MAX_DECIM)) begin
            sum_i_ff <= sum_i_ff + SUM_W'(rnd_i);
            sum_q_ff <= sum_q_ff + SUM_W'(rnd_q);
            cnt_ff   <= cnt_ff + 1'b1;
         end
         if (cmd.num) begin
            sum_i_ff <= '0;
            sum_q_ff <= '0;
            cnt_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         si_ff    <= in_i;
         sq_ff    <= in_q;
         rpsum_ff <= rp_ff + {1'b0, out_rate_ff};
      end
      if (cmd.look) begin
         sin_ff <= tab_sin(idx);
         cos_ff <= tab_sin(cidx);
      end
      if (cmd.mul) begin
         p_ic_ff <= si_ff * cos_ff;
         p_qs_ff <= sq_ff * sin_ff;
         p_is_ff <= si_ff * sin_ff;
         p_qc_ff <= sq_ff * cos_ff;
      end
      if (cmd.num) begin
         num_i_ff <= mag_i + SUM_W'(cnt_ff >> 1);
         num_q_ff <= mag_q + SUM_W'(cnt_ff >> 1);
         neg_i_ff <= sum_i_ff[SUM_W-1];
         neg_q_ff <= sum_q_ff[SUM_W-1];
         zero_ff  <= (cnt_ff == '0);
         den_ff   <= cnt_ff;
      end
      if (div_done) begin
         if (cmd.div_q) res_q_ff <= res;
         else           res_i_ff <= res;
      end
      if (cmd.load_out) begin
         out_i_ff <= res_i_ff;
         out_q_ff <= res_q_ff;
      end
   end

   assign stat.emit     = emit_ff;
   assign stat.div_done = div_done;
   assign out_i         = out_i_ff;
   assign out_q         = out_q_ff;

endmodule

@@ rtl/iqddc_ctrl.sv @@
`timescale 1ns / 1ps
module iqddc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  iqddc_pkg::iqddc_stat_type stat,
   output iqddc_pkg::iqddc_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOK, ST_MUL, ST_ACC, ST_NUM,
      ST_DIV_I_GO, ST_DIV_I_WAIT, ST_DIV_Q_GO, ST_DIV_Q_WAIT, ST_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.look      = (state_ff == ST_LOOK);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.acc       = (state_ff == ST_ACC);
      cmd.num       = (state_ff == ST_NUM);
      cmd.div_start = (state_ff == ST_DIV_I_GO) || (state_ff == ST_DIV_Q_GO);
      cmd.div_q     = (state_ff == ST_DIV_Q_GO) || (state_ff == ST_DIV_Q_WAIT);
      cmd.load_out  = (state_ff == ST_HOLD) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out)    rsp_valid_ff <= 1'b1;
         else if (rsp_ready)  rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:       if (req_valid) state_ff <= ST_LOOK;
            ST_LOOK:       state_ff <= ST_MUL;
            ST_MUL:        state_ff <= ST_ACC;
            ST_ACC:        state_ff <= stat.emit ? ST_NUM : ST_IDLE;
            ST_NUM:        state_ff <= ST_DIV_I_GO;
            ST_DIV_I_GO:   state_ff <= ST_DIV_I_WAIT;
            ST_DIV_I_WAIT: if (stat.div_done) state_ff <= ST_DIV_Q_GO;
            ST_DIV_Q_GO:   state_ff <= ST_DIV_Q_WAIT;
            ST_DIV_Q_WAIT: if (stat.div_done) state_ff <= ST_HOLD;
            ST_HOLD:       if (slot_free) state_ff <= ST_IDLE;
            default:       state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/iq_downconvert_boxcar_resample.sv @@
`timescale 1ns / 1ps
// Digital downconverter: each IQ word is mixed with the cosine and sine of an NCO
// phase (table lookup, no interpolation), summed into a boxcar average, and a
// fractional resampler decides when the rounded average leaves as one result word.
// One word is in flight at a time: an accepted word passes through table lookup,
// multiply and accumulate before the next word is accepted; a word that gives a
// result also has both averages formed in turn by the shared one-bit-per-cycle
// divider and waits for the output register to be free. A finished result waits
// in an output register, so new words keep being accepted while it is not yet
// taken. Configuration writes are taken in any cycle.
module iq_downconvert_boxcar_resample #(
   parameter int MAX_DECIM  = iqddc_pkg::MAX_DECIM_DEF,
   parameter int TABLE_BITS = iqddc_pkg::TABLE_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   iqddc_in_if.sink    req,
   iqddc_out_if.source rsp,
   iqddc_csr_if.sink   csr
);

   iqddc_pkg::iqddc_cmd_type  cmd;
   iqddc_pkg::iqddc_stat_type stat;

   assign csr.ready = 1'b1;

   iqddc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   iqddc_dp #(.MAX_DECIM(MAX_DECIM), .TABLE_BITS(TABLE_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr.valid),
      .csr_index (csr.index),
      .csr_data  (csr.data),
      .in_i      (req.in_i),
      .in_q      (req.in_q),
      .out_i     (rsp.out_i),
      .out_q     (rsp.out_q)
   );

endmodule
